FILE: hdl/top_k_score_queue_assert.svh
// Assertion macros for the top-k score queue checkers.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef TOP_K_SCORE_QUEUE_ASSERT_SVH
`define TOP_K_SCORE_QUEUE_ASSERT_SVH

// Property sampled on clk, held off while reset is asserted.
`define TKSQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property sampled on clk that must also hold during reset.
`define TKSQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/tksq_pkg.sv
// Shared types and constants of the top-k score queue.
// No dependencies; the interfaces, controller, datapath, top level and bench use it.
`timescale 1ns / 1ps

package tksq_pkg;

  localparam int MAX_KEPT_DEF = 16;
  localparam int KEEP_W       = 5;
  localparam int ID_W         = 32;
  localparam int SCORE_W      = 32;

  typedef logic [1:0]              cmd_code_t;
  typedef logic [KEEP_W-1:0]       keep_cnt_t;
  typedef logic [ID_W-1:0]         doc_id_t;
  typedef logic signed [SCORE_W-1:0] score_t;

  localparam cmd_code_t CMD_INSERT = 2'd0;
  localparam cmd_code_t CMD_READ   = 2'd1;
  localparam cmd_code_t CMD_CLEAR  = 2'd2;

  localparam keep_cnt_t KEEP_RST = 5'd16;

  // controller to datapath
  typedef struct packed {
    logic insert;
    logic clear;
    logic cfg_load;
    logic load_empty;
    logic read_step;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic store_empty;
    logic read_last;
  } dp_stat_t;

endpackage

FILE: hdl/tksq_if.sv
// Valid/ready channel interfaces for requests and results of the queue.
// Depends on tksq_pkg for the payload types.
`timescale 1ns / 1ps

interface tksq_in_if;
  logic               valid;
  logic               ready;
  tksq_pkg::cmd_code_t command;
  tksq_pkg::doc_id_t   doc_id;
  tksq_pkg::score_t    doc_score;

  modport source (output valid, command, doc_id, doc_score, input ready);
  modport sink   (input valid, command, doc_id, doc_score, output ready);
endinterface

interface tksq_out_if;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              threshold_changed;
  tksq_pkg::doc_id_t out_doc_id;
  tksq_pkg::score_t  out_score;
  logic              entry_valid;
  logic              last_of_run;

  modport source (output valid, accepted, threshold_changed, out_doc_id, out_score,
                  entry_valid, last_of_run, input ready);
  modport sink   (input valid, accepted, threshold_changed, out_doc_id, out_score,
                  entry_valid, last_of_run, output ready);
endinterface

FILE: hdl/tksq_ctrl.sv
// Controller of the top-k score queue: request decode, read sequencing,
// output valid. Depends on tksq_pkg.
`timescale 1ns / 1ps

module tksq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tksq_pkg::cmd_code_t in_command,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_we,
  output tksq_pkg::dp_cmd_t   dp_cmd,
  input  tksq_pkg::dp_stat_t  dp_stat
);
  import tksq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   req;
  logic   load;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign req       = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    dp_cmd    = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req) begin
          if (in_command == CMD_INSERT) begin
            dp_cmd.insert = 1'b1;
          end else if (in_command == CMD_CLEAR) begin
            dp_cmd.clear = 1'b1;
          end else if (in_command == CMD_READ) begin
            if (dp_stat.store_empty) begin
              dp_cmd.load_empty = 1'b1;
            end else begin
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        // emit one ranked entry each time the output slot frees up
        if (slot_free) begin
          dp_cmd.read_step = 1'b1;
          if (dp_stat.read_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    dp_cmd.cfg_load = cfg_we;
  end

  assign load = dp_cmd.insert || dp_cmd.load_empty || dp_cmd.read_step;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/tksq_datapath.sv
// Datapath of the top-k score queue: sorted compare-and-shift cell row,
// fill and capacity registers, result register. Depends on tksq_pkg.
`timescale 1ns / 1ps

module tksq_datapath #(
  parameter int MAX_KEPT = tksq_pkg::MAX_KEPT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tksq_pkg::dp_cmd_t  dp_cmd,
  output tksq_pkg::dp_stat_t dp_stat,
  input  tksq_pkg::doc_id_t  in_doc_id,
  input  tksq_pkg::score_t   in_doc_score,
  input  tksq_pkg::keep_cnt_t cfg_wdata,
  output logic               out_accepted,
  output logic               out_threshold_changed,
  output tksq_pkg::doc_id_t  out_doc_id,
  output tksq_pkg::score_t   out_score,
  output logic               out_entry_valid,
  output logic               out_last_of_run
);
  import tksq_pkg::*;

  localparam int CNT_W   = $clog2(MAX_KEPT + 1);
  localparam int CAP_RST = (int'(KEEP_RST) > MAX_KEPT) ? MAX_KEPT : int'(KEEP_RST);

  doc_id_t cell_id_r  [MAX_KEPT];
  score_t  cell_sc_r  [MAX_KEPT];
  doc_id_t cell_id_nxt[MAX_KEPT];
  score_t  cell_sc_nxt[MAX_KEPT];
  doc_id_t sh_id      [MAX_KEPT];
  score_t  sh_sc      [MAX_KEPT];
  doc_id_t up_id      [MAX_KEPT];
  score_t  up_sc      [MAX_KEPT];

  logic [CNT_W-1:0] fill_r, fill_nxt, cap_r, cap_nxt, rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0] fill_ins;
  logic [MAX_KEPT-1:0] ge, last_sel, wrap_sel;
  logic [MAX_KEPT:0]   ge_ext;
  logic full, ins_ok, thr_chg, read_last;

  logic    res_acc_r, res_thr_r, res_ev_r, res_last_r;
  doc_id_t res_id_r;
  score_t  res_sc_r;

  assign full      = (fill_r == cap_r);
  assign read_last = ((rd_cnt_r + 1'b1) == fill_r);

  // per-cell compare: entry stays ahead of the candidate when its score is not lower
  always_comb begin
    for (int i = 0; i < MAX_KEPT; i++) begin
      ge[i]       = (CNT_W'(i) < fill_r) && !(cell_sc_r[i] < in_doc_score);
      last_sel[i] = (CNT_W'(i) == (cap_r - 1'b1));
      wrap_sel[i] = (CNT_W'(i) == (fill_r - 1'b1));
    end
    ge_ext = {ge, 1'b1};
  end

  assign ins_ok   = !full || !(|(last_sel & ge));
  assign fill_ins = full ? fill_r : fill_r + 1'b1;
  assign thr_chg  = ins_ok && (fill_ins == cap_r);

  // neighbor taps: shift down for insert, shift up for the read rotation
  always_comb begin
    sh_id[0] = in_doc_id;
    sh_sc[0] = in_doc_score;
    for (int i = 1; i < MAX_KEPT; i++) begin
      sh_id[i] = cell_id_r[i-1];
      sh_sc[i] = cell_sc_r[i-1];
    end
    for (int i = 0; i < MAX_KEPT - 1; i++) begin
      up_id[i] = cell_id_r[i+1];
      up_sc[i] = cell_sc_r[i+1];
    end
    up_id[MAX_KEPT-1] = cell_id_r[0];
    up_sc[MAX_KEPT-1] = cell_sc_r[0];
  end

  always_comb begin
    for (int i = 0; i < MAX_KEPT; i++) begin
      cell_id_nxt[i] = cell_id_r[i];
      cell_sc_nxt[i] = cell_sc_r[i];
      if (dp_cmd.insert && ins_ok) begin
        if (!ge[i]) begin
          cell_id_nxt[i] = ge_ext[i] ? in_doc_id    : sh_id[i];
          cell_sc_nxt[i] = ge_ext[i] ? in_doc_score : sh_sc[i];
        end
      end else if (dp_cmd.read_step) begin
        // rotate the filled part so the head is always the next entry
        cell_id_nxt[i] = wrap_sel[i] ? cell_id_r[0] : up_id[i];
        cell_sc_nxt[i] = wrap_sel[i] ? cell_sc_r[0] : up_sc[i];
      end
    end
  end

  always_comb begin
    fill_nxt   = fill_r;
    cap_nxt    = cap_r;
    rd_cnt_nxt = rd_cnt_r;
    if (dp_cmd.cfg_load) begin
      fill_nxt = '0;
      if (cfg_wdata == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (int'(cfg_wdata) > MAX_KEPT) begin
        cap_nxt = CNT_W'(MAX_KEPT);
      end else begin
        cap_nxt = CNT_W'(cfg_wdata);
      end
    end else if (dp_cmd.clear) begin
      fill_nxt = '0;
    end else if (dp_cmd.insert && ins_ok) begin
      fill_nxt = fill_ins;
    end
    if (dp_cmd.read_step) begin
      rd_cnt_nxt = read_last ? '0 : rd_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      cap_r    <= CNT_W'(CAP_RST);
      rd_cnt_r <= '0;
    end else begin
      fill_r   <= fill_nxt;
      cap_r    <= cap_nxt;
      rd_cnt_r <= rd_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_KEPT; i++) begin
      cell_id_r[i] <= cell_id_nxt[i];
      cell_sc_r[i] <= cell_sc_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.insert) begin
      res_acc_r  <= ins_ok;
      res_thr_r  <= thr_chg;
      res_id_r   <= '0;
      res_sc_r   <= '0;
      res_ev_r   <= 1'b0;
      res_last_r <= 1'b1;
    end else if (dp_cmd.load_empty) begin
      res_acc_r  <= 1'b0;
      res_thr_r  <= 1'b0;
      res_id_r   <= '0;
      res_sc_r   <= '0;
      res_ev_r   <= 1'b0;
      res_last_r <= 1'b1;
    end else if (dp_cmd.read_step) begin
      res_acc_r  <= 1'b0;
      res_thr_r  <= 1'b0;
      res_id_r   <= cell_id_r[0];
      res_sc_r   <= cell_sc_r[0];
      res_ev_r   <= 1'b1;
      res_last_r <= read_last;
    end
  end

  assign dp_stat.store_empty = (fill_r == '0);
  assign dp_stat.read_last   = read_last;

  assign out_accepted          = res_acc_r;
  assign out_threshold_changed = res_thr_r;
  assign out_doc_id            = res_id_r;
  assign out_score             = res_sc_r;
  assign out_entry_valid       = res_ev_r;
  assign out_last_of_run       = res_last_r;

endmodule

FILE: hdl/top_k_score_queue.sv
// Top-k score queue: an insert request gives one result in the register the
// following cycle; inserts and clears are taken one per cycle unless the result side stalls.
// A read of n kept entries gives n results, one per unstalled cycle, set by the
// rotation of the cell row through its head; requests wait till the last is loaded.
// Reset (synchronous, rst_n low): store empty, capacity min(16, MAX_KEPT), no clearing pass.
`timescale 1ns / 1ps

module top_k_score_queue #(
  parameter int MAX_KEPT = tksq_pkg::MAX_KEPT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  tksq_in_if.sink             in_ch,
  tksq_out_if.source          out_ch,
  input  logic                cfg_we,
  input  tksq_pkg::keep_cnt_t cfg_wdata
);
  import tksq_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  tksq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_command(in_ch.command),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  tksq_datapath #(
    .MAX_KEPT(MAX_KEPT)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .dp_cmd               (dp_cmd),
    .dp_stat              (dp_stat),
    .in_doc_id            (in_ch.doc_id),
    .in_doc_score         (in_ch.doc_score),
    .cfg_wdata            (cfg_wdata),
    .out_accepted         (out_ch.accepted),
    .out_threshold_changed(out_ch.threshold_changed),
    .out_doc_id           (out_ch.out_doc_id),
    .out_score            (out_ch.out_score),
    .out_entry_valid      (out_ch.entry_valid),
    .out_last_of_run      (out_ch.last_of_run)
  );

endmodule

FILE: hdl/tksq_checker.sv
// Port-level checks of the top-k score queue, bound to the top level.
// Depends on top_k_score_queue_assert.svh and the top level's ports.
`timescale 1ns / 1ps

module tksq_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_accepted,
  input logic out_threshold_changed,
  input logic out_entry_valid,
  input logic out_last_of_run
);
`include "top_k_score_queue_assert.svh"

  // a stalled result stays offered
  `TKSQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // a refreshed threshold only comes with an accepted insert
  `TKSQ_ASSERT(a_thr_acc, out_valid && out_threshold_changed |-> out_accepted,
               "threshold changed on reject")

  // ranked entries carry no insert flags
  `TKSQ_ASSERT(a_entry_flags,
               out_valid && out_entry_valid |-> !out_accepted && !out_threshold_changed,
               "insert flags on entry")

  // insert and empty-read results are single results
  `TKSQ_ASSERT(a_single_last, out_valid && !out_entry_valid |-> out_last_of_run,
               "single result not last")

  // no new request while a read run is still going
  `TKSQ_ASSERT(a_read_block,
               out_valid && out_entry_valid && !out_last_of_run |-> !in_ready,
               "request taken mid read")

endmodule

bind top_k_score_queue tksq_checker u_tksq_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_accepted         (out_ch.accepted),
  .out_threshold_changed(out_ch.threshold_changed),
  .out_entry_valid      (out_ch.entry_valid),
  .out_last_of_run      (out_ch.last_of_run)
);

FILE: tb/sv/tb_top.sv
// Self-checking bench for the top-k score queue: ranked inserts, reads, clears and capacity.
// Depends on tksq_pkg, the tksq_in_if / tksq_out_if channels and top_k_score_queue.
`timescale 1ns / 1ps

module tb_top;
  import tksq_pkg::*;

  localparam int MAX_KEPT     = MAX_KEPT_DEF;
  localparam int LIMIT_CYCLES = 100000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 80;

  // value 3 on the command field does nothing
  localparam cmd_code_t CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic    accepted;
    logic    threshold_changed;
    doc_id_t doc_id;
    score_t  score;
    logic    entry_valid;
    logic    last_of_run;
  } rank_result_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  keep_cnt_t cfg_wdata;

  tksq_in_if  in_ch ();
  tksq_out_if out_ch ();

  top_k_score_queue #(.MAX_KEPT(MAX_KEPT)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // expected view of the store
  doc_id_t      rank_ids [MAX_KEPT] = '{default: '0};
  score_t       rank_scores [MAX_KEPT] = '{default: '0};
  int           rank_fill = 0;
  score_t       rank_floor = '0;
  keep_cnt_t    rank_keep = KEEP_RST;
  rank_result_t due_results[$];

  int error_count = 0;
  int cycle_count;
  bit tx_idle_en;
  bit rx_idle_en;
  int hold_asked;
  int hold_seen = 0;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < 100)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Work out the results of one accepted request and advance the expected store.
  task automatic rank_request(cmd_code_t cmd, doc_id_t id, score_t sc);
    int cap;
    int n;
    int pos;
    rank_result_t r;
    cap = (rank_keep == 0) ? 1 : ((rank_keep > MAX_KEPT) ? MAX_KEPT : int'(rank_keep));
    n = (rank_fill > cap) ? cap : rank_fill;
    r = '0;
    r.last_of_run = 1'b1;
    case (cmd)
      CMD_INSERT: begin
        if (n >= cap && !(rank_floor < sc)) begin
          due_results.push_back(r);
        end else begin
          if (n < cap) begin
            pos = n;
            n++;
          end else begin
            pos = cap - 1;
          end
          // shift strictly lower scores down; ties keep the older entry ahead
          while (pos > 0 && rank_scores[pos-1] < sc) begin
            rank_ids[pos] = rank_ids[pos-1];
            rank_scores[pos] = rank_scores[pos-1];
            pos--;
          end
          rank_ids[pos] = id;
          rank_scores[pos] = sc;
          rank_fill = n;
          r.accepted = 1'b1;
          if (n == cap) begin
            rank_floor = rank_scores[cap-1];
            r.threshold_changed = 1'b1;
          end
          due_results.push_back(r);
        end
      end
      CMD_READ: begin
        if (n == 0) begin
          due_results.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.doc_id = rank_ids[i];
            r.score = rank_scores[i];
            r.entry_valid = 1'b1;
            r.last_of_run = (i == n - 1);
            due_results.push_back(r);
          end
        end
      end
      CMD_CLEAR: begin
        rank_fill = 0;
        rank_floor = '0;
      end
      default: begin
      end
    endcase
  endtask

  // Track config writes and accepted requests as the block sees them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        rank_keep = cfg_wdata;
        rank_fill = 0;
        rank_floor = '0;
      end
      if (in_ch.valid && in_ch.ready)
        rank_request(in_ch.command, in_ch.doc_id, in_ch.doc_score);
    end
  end

  always @(posedge clk) begin
    rank_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with none due", out_ch.out_doc_id, '0);
      end else begin
        want = due_results.pop_front();
        if (out_ch.accepted !== want.accepted)
          report_mismatch("accepted", out_ch.accepted, want.accepted);
        if (out_ch.threshold_changed !== want.threshold_changed)
          report_mismatch("threshold_changed", out_ch.threshold_changed,
                          want.threshold_changed);
        if (out_ch.out_doc_id !== want.doc_id)
          report_mismatch("out_doc_id", out_ch.out_doc_id, want.doc_id);
        if (out_ch.out_score !== want.score)
          report_mismatch("out_score", out_ch.out_score, want.score);
        if (out_ch.entry_valid !== want.entry_valid)
          report_mismatch("entry_valid", out_ch.entry_valid, want.entry_valid);
        if (out_ch.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", out_ch.last_of_run, want.last_of_run);
      end
    end
  end

  // Result side: random stalls if rx_idle_en, plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!rx_idle_en) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 20);
    end
  end

  task automatic send_request(cmd_code_t cmd, doc_id_t id, score_t sc);
    if (tx_idle_en) begin
      while ($urandom_range(0, 99) < 20) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.doc_id <= id;
    in_ch.doc_score <= sc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid, drain every due result, then give a clear time to finish.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_keep(keep_cnt_t keep);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= keep;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic score_t random_score();
    int pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0: return score_t'($urandom);
      1: return score_t'((int'($urandom_range(0, 15)) - 8) * 65536);
      2: begin
        case ($urandom_range(0, 3))
          0: return score_t'(32'h8000_0000);
          1: return score_t'(32'h7fff_ffff);
          2: return score_t'(32'h0000_0000);
          default: return score_t'(32'hffff_ffff);
        endcase
      end
      default: return score_t'(int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  task automatic test_empty_and_ignored();
    send_request(CMD_READ, 32'h0, 32'h0);
    send_request(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    send_request(CMD_CLEAR, 32'h0, 32'h0);
    send_request(CMD_READ, 32'hffff_ffff, 32'h7fff_ffff);
    settle();
  endtask

  task automatic test_rank_order();
    send_request(CMD_INSERT, 32'h0000_0000, 32'h8000_0000);
    send_request(CMD_INSERT, 32'hffff_ffff, 32'h7fff_ffff);
    send_request(CMD_INSERT, 32'h0000_1234, 32'h0000_0000);
    send_request(CMD_INSERT, 32'h0000_5678, 32'h0000_0000);
    send_request(CMD_INSERT, 32'haaaa_5555, 32'hffff_0000);
    send_request(CMD_INSERT, 32'h5555_aaaa, 32'h0001_0000);
    send_request(CMD_READ, 32'h0, 32'h0);
    send_request(CMD_CLEAR, 32'h0, 32'h0);
    send_request(CMD_READ, 32'h0, 32'h0);
    settle();
  endtask

  task automatic test_capacity_one();
    set_keep(5'd1);
    send_request(CMD_INSERT, 32'd1, 32'h0005_0000);
    send_request(CMD_INSERT, 32'd2, 32'h0003_0000);
    // equal score must not displace the kept entry
    send_request(CMD_INSERT, 32'd3, 32'h0005_0000);
    send_request(CMD_INSERT, 32'd4, 32'h0009_0000);
    send_request(CMD_READ, 32'h0, 32'h0);
    send_request(CMD_CLEAR, 32'h0, 32'h0);
    send_request(CMD_INSERT, 32'd5, 32'hffff_ffff);
    send_request(CMD_INSERT, 32'd6, 32'h8000_0000);
    send_request(CMD_INSERT, 32'd7, 32'h0000_0000);
    send_request(CMD_READ, 32'h0, 32'h0);
    settle();
  endtask

  task automatic test_random_mix(keep_cnt_t keep, int count, bit idle);
    int roll;
    tx_idle_en = idle;
    rx_idle_en = idle;
    set_keep(keep);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 72)
        send_request(CMD_INSERT, $urandom, random_score());
      else if (roll < 87)
        send_request(CMD_READ, $urandom, score_t'($urandom));
      else if (roll < 93)
        send_request(CMD_CLEAR, $urandom, score_t'($urandom));
      else
        send_request(CMD_UNUSED, $urandom, score_t'($urandom));
    end
    settle();
  endtask

  task automatic test_full_stall();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    set_keep(5'd8);
    hold_asked++;
    repeat (24) send_request(CMD_INSERT, $urandom, random_score());
    send_request(CMD_READ, 32'h0, 32'h0);
    settle();
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[top_k_score_queue] ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_INSERT;
    in_ch.doc_id = '0;
    in_ch.doc_score = '0;
    hold_asked = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_ignored();
    test_rank_order();
    test_capacity_one();
    test_random_mix(5'd4, 20, 1'b1);
    test_random_mix(5'd16, 30, 1'b0);
    test_random_mix(5'd0, 20, 1'b1);
    test_random_mix(5'd31, 20, 1'b1);
    test_random_mix(keep_cnt_t'($urandom_range(2, 15)), 20, 1'b1);
    test_random_mix(5'd2, 20, 1'b1);
    test_full_stall();

    settle();
    if (error_count == 0)
      $display("[top_k_score_queue] OK");
    else
      $display("[top_k_score_queue] ERROR");
    $finish;
  end

endmodule
